// ===== rtl/gps_pkg.sv =====
// shared types, constants and window helper for the granular pitch shifter
package gps_pkg;

   localparam int RING_DEPTH_DEF   = 4096;
   localparam int GRAIN_LENGTH_DEF = 1024;
   localparam int HOP_LENGTH_DEF   = 256;
   localparam int VOICE_COUNT_DEF  = 4;

   localparam int SAMPLE_W = 24;
   localparam int RATIO_W  = 16;
   localparam int ALPHA_W  = 16;
   localparam int FRAC_W   = 14;
   localparam int HANN_W   = 17;

   localparam logic [RATIO_W-1:0] RATIO_UNITY = 16'd16384;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'hFFFF;

   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned PI_Q30  = 64'd3373259426;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLEW,
      ST_RATIO,
      ST_RDA,
      ST_RDB,
      ST_INT,
      ST_INT2,
      ST_MAC,
      ST_ACC,
      ST_SAT,
      ST_DIV,
      ST_DONE
   } state_type;

   // squared sine of the folded q16 angle, q1.15, capped at one
   function automatic logic [HANN_W-1:0] hann_from_q(input longint unsigned q_raw);
      longint unsigned q;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned h;
      q = q_raw;
      if (q > 64'd32768) begin
         q = (q > 64'd65536) ? 64'd0 : 64'd65536 - q;
      end
      x  = (q * PI_Q30) >> 16;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      h  = (s * s) >> 30;
      h  = (h + 64'd16384) >> 15;
      if (h > 64'd32768) begin
         h = 64'd32768;
      end
      return h[HANN_W-1:0];
   endfunction

endpackage

// ===== rtl/gps_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module gps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gps_div.sv =====
// divider of an unsigned value by a small constant through a reciprocal multiply
module gps_div #(
   parameter int DW      = 26,
   parameter int DIVISOR = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int SH  = $clog2(DIVISOR);
   localparam int PRW = 2 * DW + 1;
   localparam longint unsigned MUL = ((64'd1 << (DW + SH)) + DIVISOR - 1) / DIVISOR;

   logic [DW-1:0]  din_ff, din_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic           stg_ff, stg_in;
   logic           done_ff, done_in;
   logic [PRW-1:0] prod;

   assign prod = PRW'(din_ff) * PRW'(MUL);

   always_comb begin
      din_in  = din_ff;
      quo_in  = quo_ff;
      stg_in  = 1'b0;
      done_in = 1'b0;
      if (start) begin
         din_in = dividend;
         stg_in = 1'b1;
      end
      if (stg_ff) begin
         quo_in  = DW'(prod >> (DW + SH));
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stg_ff  <= stg_in;
         done_ff <= done_in;
      end
      din_ff <= din_in;
      quo_ff <= quo_in;
   end

   assign busy     = stg_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/granular_pitch_shifter.sv =====
// granular overlap-add pitch shifter top level: sequencer, voice state and output stage
// one sample is in flight at a time: req_tready is high only in the idle state, so a new
//   sample is taken only after the last result has gone to the output register; the
//   ring read port and the per-voice loop set the pace
// reset clears the sequencer, voices and fill marker, sets ratio to unity; unwritten ring
//   entries read as zero through the fill marker, so no clearing pass is needed
module granular_pitch_shifter
   import gps_pkg::*;
#(
   parameter int RING_DEPTH   = RING_DEPTH_DEF,
   parameter int GRAIN_LENGTH = GRAIN_LENGTH_DEF,
   parameter int HOP_LENGTH   = HOP_LENGTH_DEF,
   parameter int VOICE_COUNT  = VOICE_COUNT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // sample_in[23:0], target_ratio[39:24]
   input  logic [0:0]    req_tuser,   // block_start[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,   // sample_out[23:0]
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);

   localparam int AW     = $clog2(RING_DEPTH);
   localparam int PW     = AW + FRAC_W;
   localparam int GW     = $clog2(GRAIN_LENGTH + 1);
   localparam int GIW    = $clog2(GRAIN_LENGTH);
   localparam int HW     = $clog2(HOP_LENGTH + 1);
   localparam int VW     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int IW     = SAMPLE_W + 1;
   localparam int FPW    = IW + FRAC_W + 1;
   localparam int WPW    = IW + HANN_W + 1;
   localparam int ACC_W  = WPW + $clog2(VOICE_COUNT);
   localparam int TW     = ACC_W - 15;
   localparam int DW     = SAMPLE_W + $clog2(VOICE_COUNT);
   localparam logic [AW-1:0] GOFF    = AW'((GRAIN_LENGTH / 2) % RING_DEPTH);
   localparam logic [AW:0]   RING_N  = (AW+1)'(RING_DEPTH);
   localparam logic [PW:0]   SPAN    = (PW+1)'(longint'(RING_DEPTH) << FRAC_W);
   localparam logic signed [ACC_W-1:0] HALF_D = ACC_W'(VOICE_COUNT * 16384);
   localparam logic signed [TW-1:0]    LIM    = TW'(longint'(VOICE_COUNT) << 23);

   logic [HANN_W-1:0] hann_rom [GRAIN_LENGTH];

   for (genvar g = 0; g < GRAIN_LENGTH; g++) begin : g_hann
      localparam longint unsigned QV =
         (longint'(g) * 65536 + (GRAIN_LENGTH - 1) / 2) / (GRAIN_LENGTH - 1);
      assign hann_rom[g] = hann_from_q(QV);
   end

   state_type state_ff, state_in;

   logic [ALPHA_W-1:0]         alpha_ff;
   logic [SAMPLE_W-1:0]        smp_ff, smp_in;
   logic [RATIO_W-1:0]         tgt_ff, tgt_in;
   logic                       bs_ff, bs_in;
   logic [RATIO_W-1:0]         ratio_ff, ratio_in;
   logic                       up_ff, up_in;
   logic [31:0]                slew_ff, slew_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic                       full_ff, full_in;
   logic [HW-1:0]              hop_ff, hop_in;
   logic [VOICE_COUNT-1:0]     act_ff, act_in;
   logic [PW-1:0]              pos_ff [VOICE_COUNT];
   logic [PW-1:0]              pos_in [VOICE_COUNT];
   logic [GW-1:0]              ph_ff [VOICE_COUNT];
   logic [GW-1:0]              ph_in [VOICE_COUNT];
   logic [VW-1:0]              vidx_ff, vidx_in;
   logic                       aok_ff, aok_in;
   logic                       bok_ff, bok_in;
   logic signed [IW-1:0]       a_ff, a_in;
   logic signed [FPW-1:0]      fp_ff, fp_in;
   logic [HANN_W-1:0]          hann_ff, hann_in;
   logic signed [IW-1:0]       samp_ff, samp_in;
   logic signed [WPW-1:0]      wp_prod_ff, wp_prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [SAMPLE_W-1:0]        res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [SAMPLE_W-1:0]        ram_rd_data;
   logic                       div_start;
   logic [DW-1:0]              div_dividend;
   logic                       div_busy;
   logic                       div_done;
   logic [DW-1:0]              div_quot;

   logic [AW-1:0]              i0, i1, start_addr;
   logic [RATIO_W-1:0]         mag;
   logic [16:0]                step;
   logic                       found;
   logic [VW-1:0]              idle_v;
   logic signed [IW-1:0]       bval, diff;
   logic signed [FPW-1:0]      fpr;
   logic signed [ACC_W-1:0]    accr;
   logic signed [TW-1:0]       tval;
   logic [PW:0]                npos;
   logic [GW-1:0]              nph;
   logic [GIW-1:0]             ph_idx;

   gps_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wp_ff),
      .wr_data(smp_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   gps_div #(.DW(DW), .DIVISOR(VOICE_COUNT)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(div_quot)
   );

   assign i0     = pos_ff[vidx_ff][PW-1:FRAC_W];
   assign i1     = (i0 == AW'(RING_DEPTH - 1)) ? '0 : i0 + 1'b1;
   assign ph_idx = ph_ff[vidx_ff][GIW-1:0];
   assign start_addr = (wp_ff < GOFF) ? AW'({1'b0, wp_ff} + RING_N - {1'b0, GOFF})
                                      : wp_ff - GOFF;
   assign mag    = up_ff ? tgt_ff - ratio_ff : ratio_ff - tgt_ff;
   assign step   = 17'((33'(slew_ff) + 33'd32768) >> 16);
   assign bval   = bok_ff ? IW'($signed(ram_rd_data)) : '0;
   assign diff   = bval - a_ff;
   assign fpr    = (fp_ff + FPW'(8192)) >>> FRAC_W;
   assign accr   = acc_ff + HALF_D;
   assign tval   = TW'(accr >>> 15);
   assign npos   = {1'b0, pos_ff[vidx_ff]} + (PW+1)'(ratio_ff);
   assign nph    = ph_ff[vidx_ff] + 1'b1;

   always_comb begin
      found  = 1'b0;
      idle_v = '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
         if (!act_ff[v] && !found) begin
            found  = 1'b1;
            idle_v = VW'(v);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      smp_in       = smp_ff;
      tgt_in       = tgt_ff;
      bs_in        = bs_ff;
      ratio_in     = ratio_ff;
      up_in        = up_ff;
      slew_in      = slew_ff;
      wp_in        = wp_ff;
      full_in      = full_ff;
      hop_in       = hop_ff;
      act_in       = act_ff;
      pos_in       = pos_ff;
      ph_in        = ph_ff;
      vidx_in      = vidx_ff;
      aok_in       = aok_ff;
      bok_in       = bok_ff;
      a_in         = a_ff;
      fp_in        = fp_ff;
      hann_in      = hann_ff;
      samp_in      = samp_ff;
      wp_prod_in   = wp_prod_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = i0;
      div_start    = 1'b0;
      div_dividend = DW'(tval + LIM);
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               smp_in   = req_tdata[23:0];
               tgt_in   = req_tdata[39:24];
               bs_in    = req_tuser[0];
               up_in    = req_tdata[39:24] >= ratio_ff;
               state_in = ST_SLEW;
            end
         end
         ST_SLEW: begin
            slew_in   = 32'(mag) * 32'(alpha_ff);
            ram_wr_en = 1'b1;
            if (wp_ff == AW'(RING_DEPTH - 1)) begin
               wp_in   = '0;
               full_in = 1'b1;
            end else begin
               wp_in = wp_ff + 1'b1;
            end
            if (hop_ff == '0) begin
               hop_in = HW'(HOP_LENGTH - 1);
               if (found) begin
                  act_in[idle_v] = 1'b1;
                  pos_in[idle_v] = {start_addr, FRAC_W'(0)};
                  ph_in[idle_v]  = '0;
               end
            end else begin
               hop_in = hop_ff - 1'b1;
            end
            acc_in   = '0;
            vidx_in  = '0;
            state_in = ST_RATIO;
         end
         ST_RATIO: begin
            if (bs_ff) begin
               ratio_in = up_ff ? ratio_ff + step[RATIO_W-1:0]
                                : ratio_ff - step[RATIO_W-1:0];
            end
            state_in = ST_RDA;
         end
         ST_RDA: begin
            if (act_ff[vidx_ff]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = i0;
               aok_in      = full_ff || (i0 < wp_ff);
               state_in    = ST_RDB;
            end else if (vidx_ff == VW'(VOICE_COUNT - 1)) begin
               state_in = ST_SAT;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
         end
         ST_RDB: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = i1;
            bok_in      = full_ff || (i1 < wp_ff);
            a_in        = aok_ff ? IW'($signed(ram_rd_data)) : '0;
            state_in    = ST_INT;
         end
         ST_INT: begin
            fp_in    = FPW'($signed({1'b0, pos_ff[vidx_ff][FRAC_W-1:0]})) * FPW'(diff);
            hann_in  = hann_rom[ph_idx];
            state_in = ST_INT2;
         end
         ST_INT2: begin
            samp_in  = a_ff + IW'(fpr);
            state_in = ST_MAC;
         end
         ST_MAC: begin
            wp_prod_in = WPW'(samp_ff) * WPW'($signed({1'b0, hann_ff}));
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            if (ph_ff[vidx_ff] < GW'(GRAIN_LENGTH)) begin
               acc_in = acc_ff + ACC_W'(wp_prod_ff);
            end
            pos_in[vidx_ff] = (npos >= SPAN) ? PW'(npos - SPAN) : PW'(npos);
            ph_in[vidx_ff]  = nph;
            if (nph >= GW'(GRAIN_LENGTH)) begin
               act_in[vidx_ff] = 1'b0;
            end
            if (vidx_ff == VW'(VOICE_COUNT - 1)) begin
               state_in = ST_SAT;
            end else begin
               vidx_in  = vidx_ff + 1'b1;
               state_in = ST_RDA;
            end
         end
         ST_SAT: begin
            if (tval >= LIM) begin
               res_in   = 24'h7FFFFF;
               state_in = ST_DONE;
            end else if (tval < -LIM) begin
               res_in   = 24'h800000;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = {~div_quot[SAMPLE_W-1], div_quot[SAMPLE_W-2:0]};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALPHA_RESET;
         ratio_ff     <= RATIO_UNITY;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         hop_ff       <= '0;
         act_ff       <= '0;
         vidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            pos_ff[v] <= '0;
            ph_ff[v]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            alpha_ff <= csr_wr_data;
         end
         ratio_ff     <= ratio_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         hop_ff       <= hop_in;
         act_ff       <= act_in;
         vidx_ff      <= vidx_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         ph_ff        <= ph_in;
      end
      smp_ff     <= smp_in;
      tgt_ff     <= tgt_in;
      bs_ff      <= bs_in;
      up_ff      <= up_in;
      slew_ff    <= slew_in;
      aok_ff     <= aok_in;
      bok_ff     <= bok_in;
      a_ff       <= a_in;
      fp_ff      <= fp_in;
      hann_ff    <= hann_in;
      samp_ff    <= samp_in;
      wp_prod_ff <= wp_prod_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("divider busy while taking a new sample");

   a_accept_writes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SLEW))
      else $error("accepted sample did not go to the ring write");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      act_ff[vidx_ff] |-> (ph_ff[vidx_ff] < GW'(GRAIN_LENGTH)))
      else $error("active voice past grain end");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule
